@@ rtl/kefc_pkg.sv @@
// ----------------------------------------------------------------------------
// kefc_pkg
// Shared types and constants of the keyboard event FIFO controller.
// ----------------------------------------------------------------------------
package kefc_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 64;
	localparam logic [31:0] RAM_BYTES_RST = 32'd1048576;

	localparam logic [1:0] MODE_KEY   = 2'd0;
	localparam logic [1:0] MODE_TEXT  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_WRITE = 2'd3;

	localparam logic [2:0] OFF_STATUS = 3'd0;
	localparam logic [2:0] OFF_EVENT  = 3'd1;
	localparam logic [2:0] OFF_TEXT   = 3'd2;
	localparam logic [2:0] OFF_KEY    = 3'd3;
	localparam logic [2:0] OFF_COUNT  = 3'd4;
	localparam logic [2:0] OFF_ADDR   = 3'd5;
	localparam logic [2:0] OFF_LENGTH = 3'd6;
	localparam logic [2:0] OFF_CMD    = 3'd7;

	localparam logic [31:0] CMD_BLOCK_READ = 32'd1;
	localparam logic [20:0] CP_SPACE = 21'd32;
	localparam logic [20:0] CP_DEL   = 21'd127;

	// One result transaction.
	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        keystroke_valid;
		logic [31:0] keystroke;
		logic        mem_write_valid;
		logic [31:0] mem_addr;
		logic [31:0] mem_data;
		logic        last;
	} result_t;

endpackage

@@ rtl/kefc_ring.sv @@
// ----------------------------------------------------------------------------
// kefc_ring
// One ring FIFO: a synchronous memory with head and tail pointers.
// A push into a full ring is dropped; pop data is registered and appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module kefc_ring #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             pushed,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0] head_q, tail_q, tail_nx, head_nx;
	logic full;

	assign tail_nx = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign head_nx = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign full = (tail_nx == head_q);
	assign not_empty = (head_q != tail_q);
	assign pushed = push && !full;

	always_ff @(posedge clk) begin
		if (pushed) mem[tail_q] <= push_data;
		pop_data <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (pushed) tail_q <= tail_nx;
			if (pop && not_empty) head_q <= head_nx;
		end
	end
endmodule

@@ rtl/keyboard_event_fifo_controller_top.sv @@
// ----------------------------------------------------------------------------
// keyboard_event_fifo_controller_top
// Keyboard controller with event, text and keystroke ring FIFOs.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Its results
// come out one per cycle, each marked by result_valid for exactly one cycle;
// the receiver cannot stall them, and last marks the final one.
// Host key and text items, and bus writes other than a block read command,
// read the FIFO memory in the accept cycle and go to the result state, which
// presents the result. Bus reads work the same way: the popped entry comes
// out of the memory in the cycle after its read address is applied.
// A block read command walks the event FIFO, one memory word per cycle. For
// N words (N up to FIFO_DEPTH-1) busy stays high through the walk and the
// cycle that ends it; the last word is presented in the first cycle in which
// a new item can already be taken. A block read that writes no word presents
// its single result from the result state. The walk is bounded by the clamped
// length and the queued events. The ram_bytes register is written through
// cfg_valid/cfg_ready; the user is to write it only while idle, which the block
// does not enforce. cfg_ready is always high. Reset clears all pointers, the
// block registers and the count; FIFO contents stay undefined until written.
// ----------------------------------------------------------------------------
module keyboard_event_fifo_controller_top
	import kefc_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] key_code,
	input  logic        key_pressed,
	input  logic        key_is_named,
	input  logic [20:0] code_point,
	input  logic [2:0]  bus_offset,
	input  logic [31:0] bus_wdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] read_data,
	output logic        irq,
	output logic        keystroke_valid,
	output logic [31:0] keystroke,
	output logic        mem_write_valid,
	output logic [31:0] mem_addr,
	output logic [31:0] mem_data,
	output logic        last
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RES  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	logic [1:0] state_q;
	logic [31:0] ram_bytes_q, blk_addr_q, blk_len_q, size_q, waddr_q;
	logic [CW-1:0] count_q, n_q;
	logic [1:0] mode_q;
	logic [2:0] off_q;
	logic irq_q, ksv_q;
	logic [31:0] ks_q;
	result_t res_q;

	logic acc;
	assign acc = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Ring controls.
	logic ev_push, ev_pushed, ev_pop, ev_ne;
	logic tx_push, tx_pushed, tx_pop, tx_ne;
	logic ky_push, ky_pushed, ky_pop, ky_ne;
	logic [16:0] ev_rd;
	logic [20:0] tx_rd;
	logic [21:0] ky_rd, ky_wd;
	logic printable, named_press, walk_go;

	assign named_press = key_pressed && key_is_named;
	assign printable = (code_point >= CP_SPACE) && (code_point != CP_DEL);
	assign ev_push = acc && mode == MODE_KEY;
	assign tx_push = acc && mode == MODE_TEXT;
	assign ky_push = acc && ((mode == MODE_KEY && named_press)
		|| (mode == MODE_TEXT && printable));
	assign ky_wd = (mode == MODE_KEY) ? {1'b1, 5'd0, key_code} : {1'b0, code_point};
	assign ev_pop = (acc && mode == MODE_READ && bus_offset == OFF_EVENT) || walk_go;
	assign tx_pop = acc && mode == MODE_READ && bus_offset == OFF_TEXT;
	assign ky_pop = acc && mode == MODE_READ && bus_offset == OFF_KEY;

	// Walk: a word fits while (n+1)*4 <= size and an event remains.
	logic [33:0] need;
	assign need = 34'({n_q, 2'b00}) + 34'd4;
	assign walk_go = (state_q == ST_WALK) && ev_ne && (need <= {2'b00, size_q})
		&& (n_q < CW'(FIFO_DEPTH));

	kefc_ring #(.DEPTH(FIFO_DEPTH), .WIDTH(17)) u_ev (
		.clk, .arst_n, .push(ev_push), .push_data({key_pressed, key_code}),
		.pushed(ev_pushed), .pop(ev_pop), .pop_data(ev_rd), .not_empty(ev_ne));
	kefc_ring #(.DEPTH(FIFO_DEPTH), .WIDTH(21)) u_tx (
		.clk, .arst_n, .push(tx_push), .push_data(code_point),
		.pushed(tx_pushed), .pop(tx_pop), .pop_data(tx_rd), .not_empty(tx_ne));
	kefc_ring #(.DEPTH(FIFO_DEPTH), .WIDTH(22)) u_ky (
		.clk, .arst_n, .push(ky_push), .push_data(ky_wd),
		.pushed(ky_pushed), .pop(ky_pop), .pop_data(ky_rd), .not_empty(ky_ne));

	// Clamped block size, computed at command accept.
	logic [31:0] room, size_d;
	assign room = ram_bytes_q - blk_addr_q;
	assign size_d = (blk_len_q == '0 || blk_addr_q >= ram_bytes_q) ? '0 :
		((blk_len_q < room) ? blk_len_q : room);

	logic [31:0] rd_d;
	logic emptyflag_q;
	logic [2:0] status_q;
	logic walk_v_q;
	logic ks_pop_ok_q;

	always_comb begin
		rd_d = '0;
		unique case (off_q)
			OFF_STATUS: rd_d = {29'd0, status_q};
			OFF_EVENT:  rd_d = emptyflag_q ? {15'd0, ev_rd} : '0;
			OFF_TEXT:   rd_d = emptyflag_q ? {11'd0, tx_rd} : '0;
			OFF_KEY:    rd_d = emptyflag_q ? {ky_rd[21], 10'd0, ky_rd[20:0]} : '0;
			OFF_COUNT:  rd_d = 32'(count_q);
			default:    rd_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ram_bytes_q <= RAM_BYTES_RST;
			blk_addr_q <= '0;
			blk_len_q <= '0;
			count_q <= '0;
			walk_v_q <= 1'b0;
			n_q <= '0;
		end else begin
			walk_v_q <= walk_go;
			if (cfg_valid && cfg_ready) ram_bytes_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (acc) begin
					mode_q <= mode;
					off_q <= bus_offset;
					irq_q <= ky_push || ev_pushed || tx_pushed;
					ksv_q <= ky_push;
					ks_q <= (mode == MODE_KEY) ? {1'b1, 15'd0, key_code}
						: {11'd0, code_point};
					status_q <= {ky_ne, tx_ne, ev_ne};
					emptyflag_q <= (bus_offset == OFF_EVENT) ? ev_ne :
						(bus_offset == OFF_TEXT) ? tx_ne : ky_ne;
					state_q <= ST_RES;
					if (mode == MODE_WRITE && bus_offset == OFF_ADDR) blk_addr_q <= bus_wdata;
					if (mode == MODE_WRITE && bus_offset == OFF_LENGTH) blk_len_q <= bus_wdata;
					if (mode == MODE_WRITE && bus_offset == OFF_CMD
						&& bus_wdata == CMD_BLOCK_READ) begin
						size_q <= size_d;
						n_q <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_RES: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_go) begin
						n_q <= n_q + 1'b1;
						waddr_q <= blk_addr_q + 32'({n_q, 2'b00});
					end else begin
						count_q <= n_q;
						// No words: a single plain result.
						if (n_q == '0) begin
							mode_q <= MODE_WRITE;
							off_q <= OFF_CMD;
							irq_q <= 1'b0;
							ksv_q <= 1'b0;
							state_q <= ST_RES;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; walk words are held in pend_r so last can be known.
	logic pend_q;
	result_t pend_r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			if (walk_v_q) pend_q <= 1'b1;
			else if (pend_q) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_v_q) begin
			pend_r <= '{read_data: '0, irq: 1'b0, keystroke_valid: 1'b0, keystroke: '0,
				mem_write_valid: 1'b1, mem_addr: waddr_q, mem_data: {15'd0, ev_rd},
				last: 1'b0};
		end
	end

	always_comb begin
		res_q = '0;
		if (state_q == ST_RES) begin
			res_q.read_data = (mode_q == MODE_READ) ? rd_d : '0;
			res_q.irq = irq_q;
			res_q.keystroke_valid = ksv_q;
			res_q.keystroke = ksv_q ? ks_q : '0;
			res_q.last = 1'b1;
		end else begin
			res_q = pend_r;
			res_q.last = !walk_v_q;
		end
	end

	assign result_valid = (state_q == ST_RES) || pend_q;
	assign read_data = res_q.read_data;
	assign irq = res_q.irq;
	assign keystroke_valid = res_q.keystroke_valid;
	assign keystroke = res_q.keystroke;
	assign mem_write_valid = res_q.mem_write_valid;
	assign mem_addr = res_q.mem_addr;
	assign mem_data = res_q.mem_data;
	assign last = res_q.last;

	logic unused_ok;
	assign unused_ok = ky_pushed;
endmodule

@@ test/tb_keyboard_event_fifo_controller_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_event_fifo_controller_top
// Self-checking bench: a behavioral copy of the three keyboard rings and the
// block read engine predicts every result transaction, which a checker
// compares field by field as the block emits them.
// ----------------------------------------------------------------------------
module tb_keyboard_event_fifo_controller_top;
	import kefc_pkg::*;

	localparam int DEPTH = 64;
	localparam int LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_KEY;
	logic [15:0] key_code = '0;
	logic        key_pressed = 1'b0;
	logic        key_is_named = 1'b0;
	logic [20:0] code_point = '0;
	logic [2:0]  bus_offset = OFF_STATUS;
	logic [31:0] bus_wdata = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        result_valid;
	result_t     got;

	keyboard_event_fifo_controller_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.key_code(key_code), .key_pressed(key_pressed), .key_is_named(key_is_named),
		.code_point(code_point), .bus_offset(bus_offset), .bus_wdata(bus_wdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .read_data(got.read_data), .irq(got.irq),
		.keystroke_valid(got.keystroke_valid), .keystroke(got.keystroke),
		.mem_write_valid(got.mem_write_valid), .mem_addr(got.mem_addr),
		.mem_data(got.mem_data), .last(got.last)
	);

	always #1 clk = ~clk;

	// Predictor state.
	logic [31:0] mem_size;
	logic [16:0] ev_ring [DEPTH];
	logic [20:0] txt_ring [DEPTH];
	logic [21:0] ks_ring [DEPTH];
	int          ev_hd, ev_tl, txt_hd, txt_tl, ks_hd, ks_tl;
	logic [31:0] blk_addr, blk_len;
	logic [31:0] blk_count;

	result_t     pending_results [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	function automatic int ring_inc(int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	function automatic void predict_item(logic [1:0] md, logic [15:0] kc, logic kp,
			logic kn, logic [20:0] cp, logic [2:0] off, logic [31:0] wd);
		result_t r;
		logic [63:0] span, room;
		int n;
		r = '0;
		case (md)
			MODE_KEY: begin
				if (kp && kn) begin
					r.keystroke = 32'h8000_0000 | kc;
					r.keystroke_valid = 1'b1;
					r.irq = 1'b1;
					if (ring_inc(ks_tl) != ks_hd) begin
						ks_ring[ks_tl] = {1'b1, 5'd0, kc};
						ks_tl = ring_inc(ks_tl);
					end
				end
				if (ring_inc(ev_tl) != ev_hd) begin
					ev_ring[ev_tl] = {kp, kc};
					ev_tl = ring_inc(ev_tl);
					r.irq = 1'b1;
				end
			end
			MODE_TEXT: begin
				if (cp >= CP_SPACE && cp != CP_DEL) begin
					r.keystroke = {11'd0, cp};
					r.keystroke_valid = 1'b1;
					r.irq = 1'b1;
					if (ring_inc(ks_tl) != ks_hd) begin
						ks_ring[ks_tl] = {1'b0, cp};
						ks_tl = ring_inc(ks_tl);
					end
				end
				if (ring_inc(txt_tl) != txt_hd) begin
					txt_ring[txt_tl] = cp;
					txt_tl = ring_inc(txt_tl);
					r.irq = 1'b1;
				end
			end
			MODE_READ: begin
				case (off)
					OFF_STATUS: r.read_data = {29'd0, ks_hd != ks_tl, txt_hd != txt_tl,
						ev_hd != ev_tl};
					OFF_EVENT: if (ev_hd != ev_tl) begin
						r.read_data = {15'd0, ev_ring[ev_hd]};
						ev_hd = ring_inc(ev_hd);
					end
					OFF_TEXT: if (txt_hd != txt_tl) begin
						r.read_data = {11'd0, txt_ring[txt_hd]};
						txt_hd = ring_inc(txt_hd);
					end
					OFF_KEY: if (ks_hd != ks_tl) begin
						r.read_data = {ks_ring[ks_hd][21], 10'd0, ks_ring[ks_hd][20:0]};
						ks_hd = ring_inc(ks_hd);
					end
					OFF_COUNT: r.read_data = blk_count;
					default: r.read_data = '0;
				endcase
			end
			default: begin
				if (off == OFF_ADDR) blk_addr = wd;
				else if (off == OFF_LENGTH) blk_len = wd;
				else if (off == OFF_CMD && wd == CMD_BLOCK_READ) begin
					span = 0;
					n = 0;
					if (blk_len != 0 && blk_addr < mem_size) begin
						room = {32'd0, mem_size} - {32'd0, blk_addr};
						span = ({32'd0, blk_len} < room) ? {32'd0, blk_len} : room;
					end
					while (64'(n + 1) * 4 <= span && ev_hd != ev_tl && n < DEPTH) begin
						result_t w;
						w = '0;
						w.mem_write_valid = 1'b1;
						w.mem_addr = blk_addr + 32'(4 * n);
						w.mem_data = {15'd0, ev_ring[ev_hd]};
						ev_hd = ring_inc(ev_hd);
						pending_results.push_back(w);
						n++;
					end
					blk_count = n;
					if (n > 0) begin
						pending_results[pending_results.size() - 1].last = 1'b1;
						return;
					end
				end
			end
		endcase
		r.last = 1'b1;
		pending_results.push_back(r);
	endfunction

	// Result checker: the block cannot be stalled, so every strobe is a transaction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (result_valid) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result transaction %p", got);
				mismatches <= mismatches + 1;
			end else begin
				if (got !== pending_results[0]) begin
					if (mismatches < 10)
						$display("result differs: expected %p got %p", pending_results[0], got);
					mismatches <= mismatches + 1;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("keyboard_event_fifo_controller_top: mismatch");
			$finish;
		end
	end

	// The block is always busy in the cycle after an accept, so releasing start
	// between items costs nothing.
	task automatic send_item(logic [1:0] md, logic [15:0] kc, logic kp, logic kn,
			logic [20:0] cp, logic [2:0] off, logic [31:0] wd);
		if (!quiet && $urandom_range(99) < 11)
			repeat ($urandom_range(1, 4)) @(posedge clk);
		start <= 1'b1;
		mode <= md;
		key_code <= kc;
		key_pressed <= kp;
		key_is_named <= kn;
		code_point <= cp;
		bus_offset <= off;
		bus_wdata <= wd;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(md, kc, kp, kn, cp, off, wd);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mem_size(logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mem_size = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed;
		send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, OFF_EVENT, 32'd0);
		send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, OFF_TEXT, 32'd0);
		send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, OFF_KEY, 32'd0);
		send_item(MODE_KEY, 16'hFFFF, 1'b1, 1'b1, 21'd0, OFF_STATUS, 32'd0);
		send_item(MODE_KEY, 16'h0000, 1'b0, 1'b1, 21'd0, OFF_STATUS, 32'd0);
		send_item(MODE_KEY, 16'h1234, 1'b1, 1'b0, 21'd0, OFF_STATUS, 32'd0);
		send_item(MODE_TEXT, 16'd0, 1'b0, 1'b0, 21'd31, OFF_STATUS, 32'd0);
		send_item(MODE_TEXT, 16'd0, 1'b0, 1'b0, CP_SPACE, OFF_STATUS, 32'd0);
		send_item(MODE_TEXT, 16'd0, 1'b0, 1'b0, CP_DEL, OFF_STATUS, 32'd0);
		send_item(MODE_TEXT, 16'd0, 1'b0, 1'b0, 21'h10FFFF, OFF_STATUS, 32'd0);
		send_item(MODE_TEXT, 16'd0, 1'b0, 1'b0, 21'h1FFFFF, OFF_STATUS, 32'd0);
		for (int o = 0; o < 8; o++)
			send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, 3'(o), 32'd0);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_STATUS, 32'hFFFF_FFFF);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, 32'd2);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
	endtask

	// Overfill the event and keystroke rings with no random delays between items,
	// then block read every queued event into memory.
	task automatic test_full_rings;
		quiet = 1'b1;
		for (int i = 0; i < DEPTH; i++)
			send_item(MODE_KEY, 16'($urandom), 1'b1, 1'b1, 21'd0, OFF_STATUS, 32'd0);
		quiet = 1'b0;
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_ADDR, 32'h0000_1000);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_LENGTH, 32'hFFFF_FFFF);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
		send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, OFF_COUNT, 32'd0);
	endtask

	// Block read bounds against the memory size, including the extremes.
	task automatic test_bounds;
		for (int i = 0; i < 3; i++)
			send_item(MODE_KEY, 16'($urandom), 1'($urandom), 1'b0, 21'd0, OFF_STATUS, 32'd0);
		set_mem_size(32'd0);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_ADDR, 32'd0);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_LENGTH, 32'd64);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
		set_mem_size(32'd10);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
		set_mem_size(32'hFFFF_FFFF);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_ADDR, 32'hFFFF_FFF8);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_LENGTH, 32'd0);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_LENGTH, 32'd7);
		send_item(MODE_WRITE, 16'd0, 1'b0, 1'b0, 21'd0, OFF_CMD, CMD_BLOCK_READ);
		send_item(MODE_READ, 16'd0, 1'b0, 1'b0, 21'd0, OFF_COUNT, 32'd0);
	endtask

	task automatic test_random;
		logic [1:0] md;
		logic [2:0] off;
		logic [31:0] wd;
		for (int i = 0; i < 10; i++) begin
			if (i == 5) begin
				case ($urandom_range(2))
					0: set_mem_size($urandom);
					1: set_mem_size($urandom_range(0, 64));
					default: set_mem_size(32'd1048576);
				endcase
			end
			md = 2'($urandom);
			off = 3'($urandom);
			wd = $urandom;
			if (md == MODE_WRITE) begin
				// Keep block addresses and lengths mostly useful.
				if (off == OFF_ADDR && $urandom_range(3) != 0) wd = $urandom_range(0, 32);
				if (off == OFF_LENGTH && $urandom_range(3) != 0) wd = $urandom_range(0, 80);
				if (off == OFF_CMD && $urandom_range(3) != 0) wd = CMD_BLOCK_READ;
			end
			send_item(md, 16'($urandom), 1'($urandom), 1'($urandom),
				($urandom_range(3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 300)),
				off, wd);
		end
	endtask

	initial begin
		mem_size = RAM_BYTES_RST;
		ev_hd = 0; ev_tl = 0; txt_hd = 0; txt_tl = 0; ks_hd = 0; ks_tl = 0;
		blk_addr = '0;
		blk_len = '0;
		blk_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rings();
		test_bounds();
		set_mem_size(32'd1048576);
		test_random();
		drain();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("keyboard_event_fifo_controller_top: match");
		else
			$display("keyboard_event_fifo_controller_top: mismatch");
		$finish;
	end

endmodule
